// ===== hw/rtl/brt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brt_pkg
// shared types and codes of the block transfer reassembly tracker
// ----------------------------------------------------------------------------
package brt_pkg;

  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned KEY_W   = 4;
  localparam int unsigned NUM_W   = 20;
  localparam int unsigned MID_W   = 16;
  localparam int unsigned SZX_W   = 3;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned ACK_W   = 24;
  localparam int unsigned ACK_NUM_SHIFT  = 4;
  localparam int unsigned ACK_MORE_SHIFT = 3;

  localparam logic [SEC_W-1:0] EXPIRY_RESET = SEC_W'(60);

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // response codes
  localparam logic [1:0] RSP_UNCHANGED  = 2'd0;
  localparam logic [1:0] RSP_CONTINUE   = 2'd1;
  localparam logic [1:0] RSP_CHANGED    = 2'd2;
  localparam logic [1:0] RSP_INCOMPLETE = 2'd3;

  // buffer actions
  localparam logic [1:0] BUF_NONE    = 2'd0;
  localparam logic [1:0] BUF_RESTART = 2'd1;
  localparam logic [1:0] BUF_APPEND  = 2'd2;

  // delivery choices
  localparam logic [1:0] DLV_NONE    = 2'd0;
  localparam logic [1:0] DLV_PAYLOAD = 2'd1;
  localparam logic [1:0] DLV_BUFFER  = 2'd2;

  // outcome classes
  localparam logic [2:0] OUT_OK         = 3'd0;
  localparam logic [2:0] OUT_DUPLICATE  = 3'd1;
  localparam logic [2:0] OUT_NO_START   = 3'd2;
  localparam logic [2:0] OUT_ID_MISMATCH = 3'd3;
  localparam logic [2:0] OUT_GAP        = 3'd4;
  localparam logic [2:0] OUT_DOUBLE_END = 3'd5;
  localparam logic [2:0] OUT_EMPTY      = 3'd6;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] stream_key;
    logic             has_payload;
    logic             has_block;
    logic [NUM_W-1:0] block_num;
    logic             more_blocks;
    logic [SZX_W-1:0] size_exp;
    logic [MID_W-1:0] message_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       response_code;
    logic             ack_option_present;
    logic [ACK_W-1:0] ack_option;
    logic [1:0]       buffer_action;
    logic [1:0]       deliver;
    logic [2:0]       outcome;
  } out_item_t;

  typedef struct packed {
    logic [MID_W-1:0] first_id;
    logic [NUM_W-1:0] last_num;
    logic             last_more;
    logic [SEC_W-1:0] stamp;
  } slot_t;

  // update of the looked-up slot
  typedef struct packed {
    logic  vld_we;
    logic  vld;
    logic  ent_we;
    slot_t ent;
  } slot_wr_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brt_slot_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brt_slot_table
// per-slot transfer state: valid flops plus entry registers, one access port
// ----------------------------------------------------------------------------
module brt_slot_table #(
  parameter int unsigned SLOTS = brt_pkg::SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IDX_W-1:0]  idx_i,
  output logic                   rd_valid_o,
  output brt_pkg::slot_t         rd_ent_o,
  input  wire brt_pkg::slot_wr_t wr_i
);

  logic [SLOTS-1:0] valid_q;
  brt_pkg::slot_t   ent_q [SLOTS];

  assign rd_valid_o = valid_q[idx_i];
  assign rd_ent_o   = ent_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.vld_we) begin
      valid_q[idx_i] <= wr_i.vld;
    end
  end

  // entry contents are only read while valid, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.ent_we) begin
      ent_q[idx_i] <= wr_i.ent;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/brt_decide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brt_decide
// classifies one request against its slot and forms result and slot update
// ----------------------------------------------------------------------------
module brt_decide (
  input  wire brt_pkg::in_item_t           item_i,
  input  wire logic                        slot_valid_i,
  input  wire brt_pkg::slot_t              slot_i,
  input  wire logic [brt_pkg::SEC_W-1:0]   seconds_i,
  input  wire logic [brt_pkg::SEC_W-1:0]   expiry_i,
  output brt_pkg::out_item_t               res_o,
  output brt_pkg::slot_wr_t                wr_o
);

  logic [brt_pkg::SEC_W-1:0] age;
  logic                      present;
  logic [brt_pkg::MID_W-1:0] first;
  logic [brt_pkg::NUM_W-1:0] num_m1;
  logic                      req;
  logic                      id_match;

  assign age      = seconds_i - slot_i.stamp;
  assign present  = slot_valid_i && (age <= expiry_i);
  assign first    = item_i.message_id - item_i.block_num[brt_pkg::MID_W-1:0];
  assign num_m1   = item_i.block_num - brt_pkg::NUM_W'(1);
  assign req      = (item_i.operation == brt_pkg::OP_REQUEST);
  assign id_match = (slot_i.first_id == first);

  always_comb begin
    res_o            = '0;
    wr_o.vld_we      = req;
    wr_o.vld         = present;
    wr_o.ent_we      = 1'b0;
    wr_o.ent         = slot_i;

    if (!item_i.has_payload) begin
      res_o.outcome = brt_pkg::OUT_EMPTY;
    end else if (!item_i.has_block) begin
      res_o.deliver = brt_pkg::DLV_PAYLOAD;
    end else begin
      res_o.ack_option_present = 1'b1;
      res_o.ack_option =
        (brt_pkg::ACK_W'(item_i.block_num) << brt_pkg::ACK_NUM_SHIFT) |
        (brt_pkg::ACK_W'(item_i.more_blocks) << brt_pkg::ACK_MORE_SHIFT) |
        brt_pkg::ACK_W'(item_i.size_exp);
      res_o.response_code = item_i.more_blocks ? brt_pkg::RSP_CONTINUE
                                               : brt_pkg::RSP_CHANGED;
      if (item_i.block_num == '0) begin
        if (present && id_match) begin
          res_o.outcome = brt_pkg::OUT_DUPLICATE;
        end else begin
          // start a fresh transfer
          wr_o.vld            = 1'b1;
          wr_o.ent_we         = req;
          wr_o.ent.first_id   = first;
          wr_o.ent.last_num   = '0;
          wr_o.ent.last_more  = item_i.more_blocks;
          wr_o.ent.stamp      = seconds_i;
          res_o.buffer_action = brt_pkg::BUF_RESTART;
          res_o.deliver       = item_i.more_blocks ? brt_pkg::DLV_NONE
                                                   : brt_pkg::DLV_BUFFER;
        end
      end else if (!present) begin
        res_o.response_code = brt_pkg::RSP_INCOMPLETE;
        res_o.outcome       = brt_pkg::OUT_NO_START;
      end else if (!id_match) begin
        res_o.response_code = brt_pkg::RSP_INCOMPLETE;
        res_o.outcome       = brt_pkg::OUT_ID_MISMATCH;
      end else if (slot_i.last_num == item_i.block_num) begin
        res_o.outcome = brt_pkg::OUT_DUPLICATE;
      end else if (slot_i.last_num != num_m1) begin
        res_o.response_code = brt_pkg::RSP_INCOMPLETE;
        res_o.outcome       = brt_pkg::OUT_GAP;
      end else if (!slot_i.last_more && !item_i.more_blocks) begin
        // second final block: track it but keep the stamp
        wr_o.ent_we        = req;
        wr_o.ent.last_num  = item_i.block_num;
        wr_o.ent.last_more = item_i.more_blocks;
        res_o.outcome      = brt_pkg::OUT_DOUBLE_END;
      end else begin
        wr_o.ent_we         = req;
        wr_o.ent.last_num   = item_i.block_num;
        wr_o.ent.last_more  = item_i.more_blocks;
        wr_o.ent.stamp      = seconds_i;
        res_o.buffer_action = brt_pkg::BUF_APPEND;
        res_o.deliver       = item_i.more_blocks ? brt_pkg::DLV_NONE
                                                 : brt_pkg::DLV_BUFFER;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/block_transfer_reassembly_tracker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_transfer_reassembly_tracker_core
// tracks block-wise uploads per stream slot and classifies each request
// ----------------------------------------------------------------------------
// path: a request beat passes the input stage register, then the result register
// throughput: one beat per cycle, requests and ticks alike, unless a held result
//   stalls the input; bound by the single table access made with the result load
// reset: all slots empty, seconds counter zero, expiry 60 s, both pipeline
//   stages empty; slot contents are left as they are and masked by valid flops
// ----------------------------------------------------------------------------
module block_transfer_reassembly_tracker_core #(
  parameter int unsigned SLOTS = brt_pkg::SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel: expiry_seconds
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [brt_pkg::SEC_W-1:0]   cfg_data_i,
  // request / tick beats
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire brt_pkg::in_item_t           in_item_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output brt_pkg::out_item_t               out_item_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // expiry register, always writable
  logic [brt_pkg::SEC_W-1:0] expiry_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= brt_pkg::EXPIRY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expiry_q <= cfg_data_i;
    end
  end

  // input stage
  logic              in_valid_q;
  brt_pkg::in_item_t in_q;
  logic              advance;
  logic              in_take;
  logic              is_req;

  // the input stage moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign is_req     = (in_q.operation == brt_pkg::OP_REQUEST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  // slot index: key modulo slot count, a small constant table over the key range
  logic [IDX_W-1:0] slot_idx;
  always_comb begin
    slot_idx = '0;
    for (int v = 0; v < (1 << brt_pkg::KEY_W); v++) begin
      if (in_q.stream_key == brt_pkg::KEY_W'(v)) begin
        slot_idx = IDX_W'(v % SLOTS);
      end
    end
  end

  // seconds counter, advanced by a tick beat leaving the input stage
  logic [brt_pkg::SEC_W-1:0] seconds_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= '0;
    end else if (advance && !is_req) begin
      seconds_q <= seconds_q + brt_pkg::SEC_W'(1);
    end
  end

  // slot lookup and classification
  logic               slot_valid;
  brt_pkg::slot_t     slot_ent;
  brt_pkg::slot_wr_t  dec_wr;
  brt_pkg::slot_wr_t  tbl_wr;
  brt_pkg::out_item_t dec_res;

  brt_decide u_decide (
    .item_i       (in_q),
    .slot_valid_i (slot_valid),
    .slot_i       (slot_ent),
    .seconds_i    (seconds_q),
    .expiry_i     (expiry_q),
    .res_o        (dec_res),
    .wr_o         (dec_wr)
  );

  // the table is written only when the request actually leaves the input stage;
  // the next beat then sees the updated slot without any forwarding
  always_comb begin
    tbl_wr        = dec_wr;
    tbl_wr.vld_we = dec_wr.vld_we && advance;
    tbl_wr.ent_we = dec_wr.ent_we && advance;
  end

  brt_slot_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .idx_i      (slot_idx),
    .rd_valid_o (slot_valid),
    .rd_ent_o   (slot_ent),
    .wr_i       (tbl_wr)
  );

  // result register, ticks produce no beat
  logic               out_valid_q;
  brt_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_req) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_req) begin
      out_q <= dec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire
